@@ sv/slfr_pkg.sv @@
// Shared types and constants of the sync/length framed byte receiver.
`default_nettype none
package slfr_pkg;

	// Default payload store depth
	localparam int MAX_PAYLOAD_DEF = 64;

	// Register reset values
	localparam logic [7:0]  SYNC_FIRST_RST   = 8'hAB;
	localparam logic [7:0]  SYNC_SECOND_RST  = 8'hCD;
	localparam logic [6:0]  LENGTH_LIMIT_RST = 7'd48;
	localparam logic [15:0] IDLE_TICKS_RST   = 16'd100;

	// Register map, one word each
	localparam int CFG_AW = 4;
	typedef enum logic [1:0] {
		REG_SYNC_FIRST   = 2'd0,
		REG_SYNC_SECOND  = 2'd1,
		REG_LENGTH_LIMIT = 2'd2,
		REG_IDLE_TICKS   = 2'd3
	} reg_idx_t;

	// Item kinds
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Configuration seen by the parser
	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [6:0]  length_limit;
		logic [15:0] idle_ticks;
	} cfg_t;

	// Frame completion handed from parser to drain
	typedef struct packed {
		logic       valid;
		logic [7:0] command;
		logic [6:0] length;
	} start_t;

	// Store address width for a given depth
	function automatic int addr_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage
`default_nettype wire

@@ sv/slfr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module slfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ sv/slfr_parser.sv @@
// Frame parser: sync/command/length tracking, idle timeout, payload writes.
`default_nettype none
module slfr_parser #(
	parameter int MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF,
	parameter int AW          = slfr_pkg::addr_bits(MAX_PAYLOAD)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire slfr_pkg::cfg_t       cfg,
	input  wire logic                 accept,
	input  wire logic                 func,
	input  wire logic [7:0]           rx_byte,
	output logic                      wr_en,
	output logic      [AW-1:0]        wr_addr,
	output logic      [7:0]           wr_data,
	output slfr_pkg::start_t          start
);
	import slfr_pkg::*;

	typedef enum logic [2:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_CMD,
		PH_LEN,
		PH_DATA
	} phase_t;

	localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

	phase_t      phase_q;
	logic [7:0]  cmd_q;
	logic [6:0]  len_q;
	logic [6:0]  cnt_q;
	logic [15:0] idle_q;

	logic       is_byte;
	logic [7:0] limit;
	logic [6:0] cnt_inc;
	logic       data_done;

	assign is_byte   = accept && (func == FUNC_BYTE);
	assign limit     = ({1'b0, cfg.length_limit} < MAX_B) ? {1'b0, cfg.length_limit} : MAX_B;
	assign cnt_inc   = 7'(cnt_q + 7'd1);
	assign data_done = (cnt_inc >= len_q);

	// Payload store write, only below capacity
	assign wr_en   = is_byte && (phase_q == PH_DATA) && ({1'b0, cnt_q} < MAX_B);
	assign wr_addr = AW'(cnt_q);
	assign wr_data = rx_byte;

	// Completed frame goes to the drain
	always_comb begin
		start.valid   = 1'b0;
		start.command = cmd_q;
		start.length  = len_q;
		if (is_byte && (phase_q == PH_LEN) && (rx_byte == 8'd0)) begin
			start.valid  = 1'b1;
			start.length = 7'd0;
		end else if (is_byte && (phase_q == PH_DATA) && data_done) begin
			start.valid = 1'b1;
		end
	end

	// Frame state and idle timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			cmd_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			idle_q  <= IDLE_TICKS_RST;
		end else if (accept && (func == FUNC_TICK)) begin
			if (idle_q < cfg.idle_ticks) begin
				idle_q <= 16'(idle_q + 16'd1);
				if (16'(idle_q + 16'd1) == cfg.idle_ticks) begin
					phase_q <= PH_SYNC1;
					cnt_q   <= '0;
				end
			end
		end else if (is_byte) begin
			idle_q <= '0;
			case (phase_q)
				PH_SYNC1: begin
					if (rx_byte == cfg.sync_first) begin
						phase_q <= PH_SYNC2;
					end
				end
				PH_SYNC2: begin
					if (rx_byte == cfg.sync_second) begin
						phase_q <= PH_CMD;
					end else begin
						phase_q <= PH_SYNC1;
						cnt_q   <= '0;
						idle_q  <= cfg.idle_ticks;
					end
				end
				PH_CMD: begin
					cmd_q   <= rx_byte;
					phase_q <= PH_LEN;
				end
				PH_LEN: begin
					if (rx_byte == 8'd0) begin
						len_q   <= '0;
						phase_q <= PH_SYNC1;
						cnt_q   <= '0;
						idle_q  <= cfg.idle_ticks;
					end else if (rx_byte <= limit) begin
						len_q   <= rx_byte[6:0];
						cnt_q   <= '0;
						phase_q <= PH_DATA;
					end else begin
						phase_q <= PH_SYNC1;
						cnt_q   <= '0;
						idle_q  <= cfg.idle_ticks;
					end
				end
				PH_DATA: begin
					cnt_q <= cnt_inc;
					if (data_done) begin
						phase_q <= PH_SYNC1;
						cnt_q   <= '0;
						idle_q  <= cfg.idle_ticks;
					end
				end
				default: begin
					phase_q <= PH_SYNC1;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ sv/slfr_drain.sv @@
// Frame drain: reads the store; one result per byte, or per empty frame.
`default_nettype none
module slfr_drain #(
	parameter int MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF,
	parameter int AW          = slfr_pkg::addr_bits(MAX_PAYLOAD)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire slfr_pkg::start_t start,
	output logic                 rd_en,
	output logic     [AW-1:0]    rd_addr,
	input  wire logic [7:0]      rd_data,
	output logic                 busy,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic     [7:0]       command,
	output logic     [6:0]       payload_length,
	output logic                 has_payload,
	output logic     [5:0]       payload_index,
	output logic     [7:0]       payload_byte,
	output logic                 last
);
	import slfr_pkg::*;

	// Read sequencer
	logic       active_q;
	logic [6:0] idx_q;
	logic [6:0] len_q;
	logic [7:0] cmd_q;
	logic [6:0] idx_inc;

	// Stage 1: RAM output register holds the byte
	logic       valid_s1;
	logic       has_s1;
	logic [6:0] idx_s1;
	logic       last_s1;

	logic move;

	assign idx_inc = 7'(idx_q + 7'd1);
	assign move    = valid_s1 && (!out_valid || out_ready);
	assign rd_en   = active_q && (!valid_s1 || move);
	assign rd_addr = AW'(idx_q);
	assign busy    = active_q || valid_s1 || out_valid;

	// Sequencer and stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			len_q    <= '0;
			cmd_q    <= '0;
			valid_s1 <= 1'b0;
			has_s1   <= 1'b0;
			idx_s1   <= '0;
			last_s1  <= 1'b0;
		end else if (start.valid) begin
			cmd_q    <= start.command;
			len_q    <= start.length;
			idx_q    <= '0;
			active_q <= (start.length != 7'd0);
			// empty frame goes straight to stage 1 with no read
			if (start.length == 7'd0) begin
				valid_s1 <= 1'b1;
				has_s1   <= 1'b0;
				idx_s1   <= '0;
				last_s1  <= 1'b1;
			end
		end else if (rd_en) begin
			idx_q    <= idx_inc;
			active_q <= (idx_inc != len_q);
			valid_s1 <= 1'b1;
			has_s1   <= 1'b1;
			idx_s1   <= idx_q;
			last_s1  <= (idx_inc == len_q);
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid      <= 1'b0;
			command        <= '0;
			payload_length <= '0;
			has_payload    <= 1'b0;
			payload_index  <= '0;
			payload_byte   <= '0;
			last           <= 1'b0;
		end else if (move) begin
			out_valid      <= 1'b1;
			command        <= cmd_q;
			payload_length <= len_q;
			has_payload    <= has_s1;
			payload_index  <= idx_s1[5:0];
			payload_byte   <= has_s1 ? rd_data : 8'd0;
			last           <= last_s1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ sv/sync_length_frame_receiver_unit.sv @@
// Top level: register port, input handshake, parser, payload store and drain.
// The first result of a frame passes the read sequencer, the store read register
// (stage 1) and the output register after its final byte is accepted; an empty
// frame skips the store read. Results then follow one per cycle while out_ready is high.
// A byte or tick is taken whenever offered; input is held off while a frame drains.
// Reset (arst_n low) restores register defaults and the parser; the store is not cleared.
`default_nettype none
module sync_length_frame_receiver_unit #(
	parameter int MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Register port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [slfr_pkg::CFG_AW-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	// Input items
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        func,
	input  wire logic [7:0]                  rx_byte,
	// Results
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [7:0]                  command,
	output logic      [6:0]                  payload_length,
	output logic                             has_payload,
	output logic      [5:0]                  payload_index,
	output logic      [7:0]                  payload_byte,
	output logic                             last
);
	import slfr_pkg::*;

	localparam int AW = addr_bits(MAX_PAYLOAD);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	start_t   start;
	logic     busy;
	logic     accept;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first   <= SYNC_FIRST_RST;
			cfg_q.sync_second  <= SYNC_SECOND_RST;
			cfg_q.length_limit <= LENGTH_LIMIT_RST;
			cfg_q.idle_ticks   <= IDLE_TICKS_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_SYNC_FIRST:   cfg_q.sync_first   <= pwdata[7:0];
				REG_SYNC_SECOND:  cfg_q.sync_second  <= pwdata[7:0];
				REG_LENGTH_LIMIT: cfg_q.length_limit <= pwdata[6:0];
				REG_IDLE_TICKS:   cfg_q.idle_ticks   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (reg_idx)
			REG_SYNC_FIRST:   prdata = {24'd0, cfg_q.sync_first};
			REG_SYNC_SECOND:  prdata = {24'd0, cfg_q.sync_second};
			REG_LENGTH_LIMIT: prdata = {25'd0, cfg_q.length_limit};
			REG_IDLE_TICKS:   prdata = {16'd0, cfg_q.idle_ticks};
			default:          prdata = '0;
		endcase
	end

	// Input transfer
	assign in_ready = !busy;
	assign accept   = in_valid && in_ready;

	slfr_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.AW          (AW)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (accept),
		.func    (func),
		.rx_byte (rx_byte),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.start   (start)
	);

	slfr_ram #(
		.WIDTH (8),
		.DEPTH (MAX_PAYLOAD),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	slfr_drain #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.AW          (AW)
	) u_drain (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.busy           (busy),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.command        (command),
		.payload_length (payload_length),
		.has_payload    (has_payload),
		.payload_index  (payload_index),
		.payload_byte   (payload_byte),
		.last           (last)
	);

endmodule
`default_nettype wire

@@ sv/slfr_checker.sv @@
// Port-level checks for the frame receiver, bound to the top level.
`default_nettype none
module slfr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] command,
	input wire logic [6:0] payload_length,
	input wire logic       has_payload,
	input wire logic [5:0] payload_index,
	input wire logic [7:0] payload_byte,
	input wire logic       last
);

	// A pending result holds its payload until the transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte)
			&& $stable(payload_index) && $stable(last))
		else $error("result changed while stalled");

	// No input is taken while a frame is being delivered
	a_no_input_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready during frame delivery");

	// Empty frame result shape
	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_payload |-> last && (payload_length == 7'd0)
			&& (payload_index == 6'd0) && (payload_byte == 8'd0))
		else $error("bad empty frame result");

	// Payload index lies inside the frame and last marks its end
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_payload |-> ({1'b0, payload_index} < payload_length)
			&& (last == ({1'b0, payload_index} + 7'd1 == payload_length)))
		else $error("payload index out of frame");

	// Results of one frame keep their command
	a_same_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last ##1 out_valid |-> $stable(command)
			&& $stable(payload_length))
		else $error("frame fields changed inside a run");

endmodule

bind sync_length_frame_receiver_unit slfr_checker u_slfr_checker (.*);
`default_nettype wire
